// ===== rtl/assert_macros.svh =====
// Assertion macros included by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ueid_pkg.sv =====
// Types and constants of the entity ID allocator
`timescale 1ns / 1ps
`default_nettype none

package ueid_pkg;

  localparam logic [31:0] QR_PRIME = 32'd4294967291;
  localparam logic [31:0] QR_HALF  = 32'd2147483645;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_DEL    = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic        vld;
    logic        del;
    logic        hit;
    logic        last;
    logic [31:0] key;
  } tok_t;

  typedef struct packed {
    logic        wr;
    logic        shift;
    logic [31:0] wr_data;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ueid_qr.sv =====
// Three-stage quadratic-residue permutation modulo 2^32-5
`timescale 1ns / 1ps
`default_nettype none

module ueid_qr (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic          last_i,
  input  wire logic [31:0]   x_i,
  output ueid_pkg::tok_t     tok_o
);

  logic [2:0]  vld_r;
  logic [2:0]  last_r;
  logic [31:0] x1_r, x2_r;
  logic [63:0] sq_r;
  logic [34:0] f1_r;
  logic [34:0] f1_nxt;
  logic [32:0] f2;
  logic [32:0] red;
  logic [31:0] res_nxt;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign f1_nxt = {3'b000, sq_r[31:0]} + {1'b0, sq_r[63:32], 2'b00} + {3'b000, sq_r[63:32]};

  always_comb begin
    f2  = {1'b0, f1_r[31:0]} + {28'd0, f1_r[34:32], 2'b00} + {30'd0, f1_r[34:32]};
    red = (f2 >= {1'b0, ueid_pkg::QR_PRIME}) ? f2 - {1'b0, ueid_pkg::QR_PRIME} : f2;
    if (x2_r >= ueid_pkg::QR_PRIME) begin
      res_nxt = x2_r;
    end else if (x2_r <= ueid_pkg::QR_HALF) begin
      res_nxt = red[31:0];
    end else begin
      res_nxt = ueid_pkg::QR_PRIME - red[31:0];
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[1:0], last_i};
    x1_r   <= x_i;
    sq_r   <= x_i * x_i;
    x2_r   <= x1_r;
    f1_r   <= f1_nxt;
    res_r  <= res_nxt;
  end

  assign tok_o = '{vld: vld_r[2], del: 1'b0, hit: 1'b0, last: last_r[2], key: res_r};

endmodule

`default_nettype wire

// ===== rtl/ueid_cell.sv =====
// One table slot: holds an ID, compares the passing token, shifts on removal
`timescale 1ns / 1ps
`default_nettype none

module ueid_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ueid_pkg::tok_t      tok_i,
  output ueid_pkg::tok_t           tok_o,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire ueid_pkg::cell_ctl_t ctl_i,
  input  wire logic [31:0]         nbr_i,
  output logic [31:0]              entry_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic           live;
  logic           match;
  logic           vld_r;
  logic           mark_r;
  logic [31:0]    entry_r;
  ueid_pkg::tok_t tok_r;
  ueid_pkg::tok_t tok_nxt;

  assign live  = IDX_C < count_i;
  assign match = tok_i.vld && live && (entry_r == tok_i.key);

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mark_r <= 1'b0;
    end else begin
      vld_r <= tok_i.vld;
      if (tok_i.vld && tok_i.del) begin
        mark_r <= tok_nxt.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (ctl_i.wr && (IDX_C == count_i)) begin
      entry_r <= ctl_i.wr_data;
    end else if (ctl_i.shift && mark_r) begin
      entry_r <= nbr_i;
    end
  end

  assign tok_o   = '{vld: vld_r, del: tok_r.del, hit: tok_r.hit, last: tok_r.last,
                     key: tok_r.key};
  assign entry_o = entry_r;

endmodule

`default_nettype wire

// ===== rtl/unique_entity_id_allocator_unit.sv =====
// Entity ID allocator: control, permutation unit and chain of table cells
// A destroy passes one token through the MAX_ENTITIES-cell chain; a create issues live_count + 1
// candidates through the permutation unit into the chain; a create on a full table skips both.
// One operation in flight at a time.
// Reset clears the live count, the state, the output valid and the flags; table contents stay undefined
// until written, and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module unique_entity_id_allocator_unit #(
  parameter int MAX_ENTITIES = 256,
  localparam int CNT_W       = $clog2(MAX_ENTITIES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_opcode,
  input  wire logic [31:0]       in_target_id,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_new_id,
  output logic [1:0]             out_status,
  output logic [CNT_W-1:0]       out_count_after
);

`include "assert_macros.svh"

  localparam int X_W = CNT_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             got_r, got_nxt;
  logic [31:0]      id_r, id_nxt;
  logic             found_r, found_nxt;
  logic             full_r, full_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [31:0]      out_id_r, out_id_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                in_acc;
  logic                fin_go;
  logic                issue;
  ueid_pkg::tok_t      qr_tok;
  ueid_pkg::tok_t      tok [MAX_ENTITIES+1];
  logic [31:0]         ent [MAX_ENTITIES];
  ueid_pkg::cell_ctl_t ctl;
  ueid_pkg::tok_t      exit_tok;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = state_r != S_IDLE;
  assign fin_go   = (state_r == S_FIN) && (!out_vld_r || !out_stall);
  assign issue    = state_r == S_ISSUE;
  assign exit_tok = tok[MAX_ENTITIES];

  ueid_qr u_qr (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (issue),
    .last_i (rem_r == '0),
    .x_i    (32'(x_r)),
    .tok_o  (qr_tok)
  );

  assign tok[0] = (in_acc && (in_opcode == ueid_pkg::OP_DEL)) ?
                  '{vld: 1'b1, del: 1'b1, hit: 1'b0, last: 1'b1, key: in_target_id} :
                  qr_tok;

  assign ctl.wr      = fin_go && (op_r == ueid_pkg::OP_CREATE) && !full_r;
  assign ctl.shift   = fin_go && (op_r == ueid_pkg::OP_DEL) && found_r;
  assign ctl.wr_data = id_r;

  for (genvar i = 0; i < MAX_ENTITIES; i++) begin : g_cell
    logic [31:0] nbr;
    if (i < MAX_ENTITIES - 1) begin : g_mid
      assign nbr = ent[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    ueid_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .count_i (count_r),
      .ctl_i   (ctl),
      .nbr_i   (nbr),
      .entry_o (ent[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    x_nxt       = x_r;
    rem_nxt     = rem_r;
    got_nxt     = got_r;
    id_nxt      = id_r;
    found_nxt   = found_r;
    full_nxt    = full_r;
    count_nxt   = count_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_id_nxt  = out_id_r;
    out_st_nxt  = out_st_r;
    out_cnt_nxt = out_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_opcode;
          got_nxt   = 1'b0;
          found_nxt = 1'b0;
          x_nxt     = X_W'(count_r);
          rem_nxt   = count_r;
          full_nxt  = (in_opcode == ueid_pkg::OP_CREATE) &&
                      (count_r == CNT_W'(MAX_ENTITIES));
          priority if (in_opcode == ueid_pkg::OP_DEL) begin
            state_nxt = S_WAIT;
          end else if (count_r == CNT_W'(MAX_ENTITIES)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        x_nxt   = x_r + 1'b1;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == '0) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (exit_tok.vld) begin
          if (exit_tok.del) begin
            found_nxt = exit_tok.hit;
          end else if (!exit_tok.hit && !got_r) begin
            got_nxt = 1'b1;
            id_nxt  = exit_tok.key;
          end
          if (exit_tok.last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt   = S_IDLE;
          out_vld_nxt = 1'b1;
          out_id_nxt  = '0;
          out_st_nxt  = ueid_pkg::ST_OK;
          if (full_r) begin
            out_st_nxt = ueid_pkg::ST_FULL;
          end else if (op_r == ueid_pkg::OP_CREATE) begin
            out_id_nxt = id_r;
            count_nxt  = count_r + 1'b1;
          end else if (found_r) begin
            count_nxt  = count_r - 1'b1;
          end else begin
            out_st_nxt = ueid_pkg::ST_MISS;
          end
          out_cnt_nxt = count_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      got_r     <= 1'b0;
      found_r   <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      got_r     <= got_nxt;
      found_r   <= found_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    rem_r     <= rem_nxt;
    id_r      <= id_nxt;
    out_id_r  <= out_id_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_new_id      = out_id_r;
  assign out_status      = out_st_r;
  assign out_count_after = out_cnt_r;

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ENTITIES), "live count above capacity")
  `ASSERT_SAME(a_exit_in_wait, exit_tok.vld, state_r == S_WAIT, "token left chain outside wait")
  `ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE, "transfer accepted but block idle")
  `ASSERT_NEXT(a_write_count, ctl.wr, count_r == CNT_W'($past(count_r) + 1'b1), "count not advanced on write")

endmodule

`default_nettype wire
